[sv/idiv64_pkg.sv]
// ============================================================================
// idiv64_pkg: shared definitions for the pipelined 64-bit integer divider
// Operation codes, pipeline control word and width/latency constants.
// ============================================================================
`default_nettype none

package idiv64_pkg;

    // Port width of every operand and result field.
    localparam int PORT_WIDTH = 64;

    // Arithmetic width; operand bits above it are ignored and the result
    // is zero-extended to the port width. Range 8 to 64.
    localparam int DATA_WIDTH = 64;

    // Edges from the accepting edge to the edge that takes the result:
    // one operand stage, one stage per quotient bit, one result stage.
    localparam int LATENCY = DATA_WIDTH + 2;

    // Operation codes carried on func.
    localparam logic [1:0] FUNC_UDIV = 2'd0;
    localparam logic [1:0] FUNC_UREM = 2'd1;
    localparam logic [1:0] FUNC_SDIV = 2'd2;
    localparam logic [1:0] FUNC_SREM = 2'd3;

    // Control word that travels down the pipeline beside the data.
    typedef struct packed {
        logic valid;    // stage holds a live transfer
        logic sel_rem;  // deliver the remainder instead of the quotient
        logic neg_res;  // negate the selected magnitude at the end
        logic zero;     // divisor was zero, result forced to zero
    } ctrl_t;

endpackage : idiv64_pkg

`default_nettype wire

[sv/idiv64_stage.sv]
// ============================================================================
// idiv64_stage: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in behind the dividend.
// ============================================================================
`default_nettype none

module idiv64_stage
    import idiv64_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_t                 ctrl_in,
    input  wire logic [DATA_WIDTH-1:0] rem_in,
    input  wire logic [DATA_WIDTH-1:0] nq_in,
    input  wire logic [DATA_WIDTH-1:0] den_in,
    output ctrl_t                      ctrl_out,
    output logic [DATA_WIDTH-1:0]      rem_out,
    output logic [DATA_WIDTH-1:0]      nq_out,
    output logic [DATA_WIDTH-1:0]      den_out
);

    ctrl_t                 ctrl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] nq_reg;
    logic [DATA_WIDTH-1:0] nq_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH:0]   partial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // The upper bit of nq holds the next unconsumed dividend bit, while the
    // low bits collect quotient bits as the dividend shifts out.
    always_comb
    begin
        partial  = {rem_in, nq_in[DATA_WIDTH-1]};
        diff     = partial - {1'b0, den_in};
        fits     = !diff[DATA_WIDTH];
        rem_next = fits ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
        nq_next  = {nq_in[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_in;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign den_out  = den_reg;

endmodule : idiv64_stage

`default_nettype wire

[sv/integer_divider_64_top.sv]
// ============================================================================
// integer_divider_64_top: pipelined 64-bit integer divider
// Unsigned and signed quotient and remainder, one bit of quotient per stage.
// ============================================================================
//
// Usage notes.
// A transfer in is taken at a rising edge where start is high and busy is
// low. The divider is fully pipelined, so busy stays low and a new operation
// may be issued in every cycle; func selects unsigned quotient, unsigned
// remainder, signed quotient truncated toward zero, or signed remainder that
// takes the sign of the dividend.
// Each operation produces exactly one result transfer: done is high for one
// cycle with result valid, and the result is taken at the edge ending that
// cycle. Results leave in the order operations entered.
// On the way from the accepting edge to the edge that takes the result, one
// stage forms operand magnitudes, one stage per quotient bit runs a restoring
// subtract, and one stage applies the sign and the zero-divisor rule.
// Throughput is one operation per cycle, set by the chain of 64 step stages,
// each holding one 65-bit subtract.
// A zero divisor yields zero. The most negative number divided by minus one
// wraps to the most negative number.
// Reset clears every valid bit, so no result appears until operations are
// issued. The receiver cannot stall, so there is no back-pressure path.
//
`default_nettype none

module integer_divider_64_top
    import idiv64_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            func,
    input  wire logic [PORT_WIDTH-1:0] dividend,
    input  wire logic [PORT_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [PORT_WIDTH-1:0]      result
);

    // ------------------------------------------------------------------
    // Operand stage: take magnitudes and work out the final sign.
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic                  neg_a;
    logic                  neg_b;
    ctrl_t                 ctrl_next;
    logic [DATA_WIDTH-1:0] mag_a_next;
    logic [DATA_WIDTH-1:0] mag_b_next;

    ctrl_t                 in_ctrl_reg;
    logic [DATA_WIDTH-1:0] mag_a_reg;
    logic [DATA_WIDTH-1:0] mag_b_reg;

    // The pipeline never stalls, so every start is a transfer.
    assign busy = 1'b0;

    always_comb
    begin
        op_a  = dividend[DATA_WIDTH-1:0];
        op_b  = divisor[DATA_WIDTH-1:0];
        // Signed operations read the top bit as the sign.
        neg_a = func[1] && op_a[DATA_WIDTH-1];
        neg_b = func[1] && op_b[DATA_WIDTH-1];
        mag_a_next = neg_a ? (~op_a + 1'b1) : op_a;
        mag_b_next = neg_b ? (~op_b + 1'b1) : op_b;

        ctrl_next.valid   = start && !busy;
        ctrl_next.zero    = (op_b == '0);
        ctrl_next.sel_rem = 1'b0;
        ctrl_next.neg_res = 1'b0;
        unique case (func)
            FUNC_UDIV:
            begin
                ctrl_next.sel_rem = 1'b0;
                ctrl_next.neg_res = 1'b0;
            end
            FUNC_UREM:
            begin
                ctrl_next.sel_rem = 1'b1;
                ctrl_next.neg_res = 1'b0;
            end
            FUNC_SDIV:
            begin
                // Quotient is negative when exactly one operand is.
                ctrl_next.sel_rem = 1'b0;
                ctrl_next.neg_res = neg_a ^ neg_b;
            end
            FUNC_SREM:
            begin
                // Remainder follows the sign of the dividend.
                ctrl_next.sel_rem = 1'b1;
                ctrl_next.neg_res = neg_a;
            end
            default:
            begin
                ctrl_next.sel_rem = 1'b0;
                ctrl_next.neg_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctrl_reg <= '0;
        end
        else
        begin
            in_ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
    end

    // ------------------------------------------------------------------
    // Step stages: stage k produces quotient bit DATA_WIDTH-1-k.
    // ------------------------------------------------------------------
    ctrl_t                 ctrl_pipe [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] rem_pipe  [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] nq_pipe   [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] den_pipe  [0:DATA_WIDTH];

    assign ctrl_pipe[0] = in_ctrl_reg;
    assign rem_pipe[0]  = '0;
    assign nq_pipe[0]   = mag_a_reg;
    assign den_pipe[0]  = mag_b_reg;

    for (genvar k = 0; k < DATA_WIDTH; k++)
    begin : g_step
        idiv64_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_pipe[k]),
            .rem_in   (rem_pipe[k]),
            .nq_in    (nq_pipe[k]),
            .den_in   (den_pipe[k]),
            .ctrl_out (ctrl_pipe[k+1]),
            .rem_out  (rem_pipe[k+1]),
            .nq_out   (nq_pipe[k+1]),
            .den_out  (den_pipe[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result stage: pick quotient or remainder, fix the sign, and force
    // zero for a zero divisor. The divisor copy ends at the last step.
    // ------------------------------------------------------------------
    ctrl_t                 fin_ctrl;
    logic [DATA_WIDTH-1:0] fin_mag;
    logic [DATA_WIDTH-1:0] fin_val;
    logic [DATA_WIDTH-1:0] unused_den;
    logic                  done_reg;
    logic [PORT_WIDTH-1:0] result_reg;
    logic [PORT_WIDTH-1:0] result_next;

    always_comb
    begin
        fin_ctrl   = ctrl_pipe[DATA_WIDTH];
        unused_den = den_pipe[DATA_WIDTH];
        fin_mag    = fin_ctrl.sel_rem ? rem_pipe[DATA_WIDTH] : nq_pipe[DATA_WIDTH];
        fin_val    = fin_ctrl.neg_res ? (~fin_mag + 1'b1) : fin_mag;
        if (fin_ctrl.zero)
        begin
            result_next = '0;
        end
        else
        begin
            result_next = PORT_WIDTH'(fin_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every result strobe traces back to an operation issued earlier.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching operation");

    // A zero divisor always yields a zero result.
    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(divisor[DATA_WIDTH-1:0], LATENCY) == '0)) |-> (result == '0))
        else $error("zero divisor gave a nonzero result");

    // An unsigned remainder is below a nonzero divisor.
    a_urem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func, LATENCY) == FUNC_UREM)
              && ($past(divisor[DATA_WIDTH-1:0], LATENCY) != '0))
        |-> (result < PORT_WIDTH'($past(divisor[DATA_WIDTH-1:0], LATENCY))))
        else $error("unsigned remainder not below divisor");

    // A nonzero signed remainder carries the sign of the dividend.
    a_srem_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(func, LATENCY) == FUNC_SREM) && (result != '0))
        |-> (result[DATA_WIDTH-1] == $past(dividend[DATA_WIDTH-1], LATENCY)))
        else $error("signed remainder sign differs from dividend");

endmodule : integer_divider_64_top

`default_nettype wire

[test/integer_divider_64_top_tb.sv]
// ============================================================================
// integer_divider_64_top_tb: self-checking bench for the 64-bit divider
// Drives quotient and remainder operations in random bursts, predicts each
// result with a bit-serial restoring division of its own, and compares every
// done strobe against the prediction for the operation that entered first.
// ============================================================================

module integer_divider_64_top_tb;

    import idiv64_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Bits that take part in the arithmetic, and the sign bit among them.
    localparam logic [PORT_WIDTH-1:0] WIDTH_MASK = {PORT_WIDTH{1'b1}} >> (PORT_WIDTH - DATA_WIDTH);
    localparam logic [PORT_WIDTH-1:0] SIGN_MASK  = {{(PORT_WIDTH-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);

    // Room for every operation of the run; the store is indexed by issue order.
    localparam int MAX_OPS       = 2048;
    localparam int RANDOM_OPS    = 926;
    // Cycles without any transfer before the run is declared hung. The longest
    // quiet stretch of a correct run is one drain pause plus one sender gap,
    // which stays far below the limit.
    localparam int STALL_LIMIT   = 20 * LATENCY;
    localparam int REPORT_LIMIT  = 40;

    // One division request waiting to be issued. When wait_drain is set the
    // sender holds it back until every earlier result has come out.
    typedef struct {
        logic [1:0]            op;
        logic [PORT_WIDTH-1:0] num;
        logic [PORT_WIDTH-1:0] den;
        bit                    wait_drain;
    } div_request_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            func;
    logic [PORT_WIDTH-1:0] dividend;
    logic [PORT_WIDTH-1:0] divisor;
    logic                  done;
    logic [PORT_WIDTH-1:0] result;

    div_request_t          request_q[$];
    logic [PORT_WIDTH-1:0] expected_result [0:MAX_OPS-1];

    // Transfer counters. Both are updated with nonblocking assignments, so
    // every process that reads them at a clock edge sees the same values.
    int ops_issued;
    int results_seen;
    int total_ops;
    int error_count;
    int idle_cycles;

    // Sender pacing, private to the driver.
    int burst_left;
    int gap_left;

    integer_divider_64_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Two's complement negation that wraps within the arithmetic width.
    function automatic logic [PORT_WIDTH-1:0] wrap_negate(input logic [PORT_WIDTH-1:0] x);
        return (~x + 1'b1) & WIDTH_MASK;
    endfunction

    // Expected result of one operation. Signed operations divide magnitudes
    // and fix the sign afterwards: the quotient is negative when the operand
    // signs differ, the remainder takes the sign of the dividend. The
    // magnitude division is the classic restoring loop, one quotient bit per
    // step from the top down, with a partial remainder one bit wider than the
    // operands so the shift can never lose a bit.
    function automatic logic [PORT_WIDTH-1:0] predict_division(
        input logic [1:0]            op,
        input logic [PORT_WIDTH-1:0] num_in,
        input logic [PORT_WIDTH-1:0] den_in
    );
        logic [PORT_WIDTH-1:0] num;
        logic [PORT_WIDTH-1:0] den;
        logic [PORT_WIDTH-1:0] mag_num;
        logic [PORT_WIDTH-1:0] mag_den;
        logic [PORT_WIDTH-1:0] quo;
        logic [PORT_WIDTH-1:0] outcome;
        logic [PORT_WIDTH:0]   partial;
        logic                  is_signed;
        logic                  neg_num;
        logic                  neg_den;
        int                    i;

        // Operand bits above the arithmetic width play no part.
        num = num_in & WIDTH_MASK;
        den = den_in & WIDTH_MASK;

        // A zero divisor gives zero whatever the operation.
        if (den == '0)
            return '0;

        is_signed = (op == FUNC_SDIV) || (op == FUNC_SREM);
        neg_num   = is_signed && ((num & SIGN_MASK) != '0);
        neg_den   = is_signed && ((den & SIGN_MASK) != '0);
        mag_num   = neg_num ? wrap_negate(num) : num;
        mag_den   = neg_den ? wrap_negate(den) : den;

        quo     = '0;
        partial = '0;
        for (i = DATA_WIDTH - 1; i >= 0; i--)
        begin
            partial = {partial[PORT_WIDTH-1:0], mag_num[i]};
            if (partial >= {1'b0, mag_den})
            begin
                partial = partial - {1'b0, mag_den};
                quo[i]  = 1'b1;
            end
        end

        // The most negative number over minus one has a magnitude quotient
        // one past the largest positive value; negating it wraps back to the
        // most negative number, which is the intended answer.
        case (op)
            FUNC_UDIV: outcome = quo;
            FUNC_UREM: outcome = partial[PORT_WIDTH-1:0];
            FUNC_SDIV: outcome = (neg_num != neg_den) ? wrap_negate(quo) : quo;
            default:   outcome = neg_num ? wrap_negate(partial[PORT_WIDTH-1:0])
                                         : partial[PORT_WIDTH-1:0];
        endcase
        return outcome & WIDTH_MASK;
    endfunction

    // Operand generator with a spread of magnitudes. Plain 64-bit random
    // values almost always give quotients of 0 or 1, so most values are
    // shifted down by a random amount and given a random sign, which makes
    // every quotient length likely. Bits above the arithmetic width are
    // filled with noise that the divider must ignore.
    function automatic logic [PORT_WIDTH-1:0] random_operand();
        logic [PORT_WIDTH-1:0] value;
        int                    shape;

        shape = $urandom_range(0, 15);
        case (shape)
            0:       value = '0;
            1, 2:    value = PORT_WIDTH'($urandom_range(1, 17));
            3:
            begin
                case ($urandom_range(0, 5))
                    0:       value = SIGN_MASK;
                    1:       value = WIDTH_MASK;
                    2:       value = SIGN_MASK - 1'b1;
                    3:       value = SIGN_MASK + 1'b1;
                    4:       value = PORT_WIDTH'(1);
                    default: value = WIDTH_MASK - 1'b1;
                endcase
            end
            4, 5, 6: value = {$urandom, $urandom};
            default: value = {$urandom, $urandom} >> $urandom_range(0, PORT_WIDTH - 1);
        endcase
        if (shape != 0 && shape != 3 && $urandom_range(0, 1) == 1)
            value = wrap_negate(value);
        value = (value & WIDTH_MASK) | ({$urandom, $urandom} & ~WIDTH_MASK);
        return value;
    endfunction

    // One line per mismatch; the count decides the verdict at the end.
    task automatic report_mismatch(
        input string                 what,
        input int                    index,
        input logic [PORT_WIDTH-1:0] got,
        input logic [PORT_WIDTH-1:0] want
    );
        if (error_count < REPORT_LIMIT)
            $display("ERROR %0t: %s, operation %0d: result %h, predicted %h",
                     $realtime, what, index, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver. A transfer in happens at an edge where start is high and busy
    // is low; the prediction for it is stored under its issue number right
    // there. The next request is then put on the ports, or start is lowered
    // for a gap. Requests leave in bursts of random length, mostly short with
    // an occasional long run of back-to-back transfers, separated by gaps of
    // random length so that quiet cycles land on every pipeline stage. A
    // request flagged to wait for a drain is held until nothing is left in
    // flight.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            func       <= FUNC_UDIV;
            dividend   <= '0;
            divisor    <= '0;
            ops_issued <= 0;
            burst_left <= $urandom_range(1, 24);
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_result[ops_issued] <= predict_division(func, dividend, divisor);
                ops_issued <= ops_issued + 1;
            end

            if (start && busy)
            begin
                // The offered request is not taken yet; keep it on the ports.
            end
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_q.size() == 0 ||
                     (request_q[0].wait_drain &&
                      ((start && !busy) || ops_issued != results_seen)))
            begin
                start <= 1'b0;
            end
            else
            begin
                div_request_t req;
                req = request_q.pop_front();
                func     <= req.op;
                dividend <= req.num;
                divisor  <= req.den;
                start    <= 1'b1;
                if (burst_left <= 1)
                begin
                    gap_left   <= $urandom_range(1, 10);
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                              : $urandom_range(1, 24);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. done marks a result for exactly one cycle and cannot be held
    // off, so the result is taken at every edge that ends a done cycle and
    // compared with the prediction for the oldest operation still waiting.
    // A result with nothing in flight is a failure of its own.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
        end
        else if (done === 1'b1)
        begin
            if (results_seen >= ops_issued)
            begin
                report_mismatch("result with no operation in flight", results_seen,
                                result, '0);
            end
            else
            begin
                if (result !== expected_result[results_seen])
                    report_mismatch("wrong result", results_seen, result,
                                    expected_result[results_seen]);
                results_seen <= results_seen + 1;
            end
        end
        else if (done !== 1'b0)
        begin
            report_mismatch("done is unknown", results_seen, result, '0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Counts cycles in which no transfer moves in either direction.
    // A correct run never comes near the limit, so reaching it means the
    // divider has stopped issuing results or stopped accepting operations.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("ERROR %0t: no transfer for %0d cycles", $realtime, idle_cycles);
                $display("integer_divider_64_top: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. The directed part goes through every
    // operation with a zero divisor, the most negative number over minus
    // one, odd dividends of either sign against divisors of the other sign,
    // the all-ones and sign-bit extremes, and a zero dividend. Random
    // requests follow; two of them wait for the pipeline to drain first, one
    // right after the directed part and one in the middle of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [1:0]            op_list [4];
        logic [PORT_WIDTH-1:0] seven;
        logic [PORT_WIDTH-1:0] two;
        div_request_t          req;
        int                    k;

        rst_n       = 1'b0;
        error_count = 0;
        idle_cycles = 0;

        op_list[0] = FUNC_UDIV;
        op_list[1] = FUNC_UREM;
        op_list[2] = FUNC_SDIV;
        op_list[3] = FUNC_SREM;
        seven = PORT_WIDTH'(7);
        two   = PORT_WIDTH'(2);

        req.wait_drain = 1'b0;
        for (k = 0; k < 4; k++)
        begin
            req.op = op_list[k];
            req.num = PORT_WIDTH'(123);         req.den = '0;
            request_q.push_back(req);
            req.num = SIGN_MASK;                req.den = WIDTH_MASK;
            request_q.push_back(req);
            req.num = wrap_negate(seven);       req.den = two;
            request_q.push_back(req);
            req.num = seven;                    req.den = wrap_negate(two);
            request_q.push_back(req);
            req.num = WIDTH_MASK;               req.den = SIGN_MASK;
            request_q.push_back(req);
            req.num = '0;                       req.den = WIDTH_MASK;
            request_q.push_back(req);
        end

        for (k = 0; k < RANDOM_OPS; k++)
        begin
            req.op         = 2'($urandom_range(0, 3));
            req.num        = random_operand();
            req.den        = random_operand();
            req.wait_drain = (k == 0) || (k == RANDOM_OPS / 2);
            request_q.push_back(req);
        end
        total_ops = request_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every operation has been issued and has come back, then let
        // the pipeline run on long enough to show any stray result.
        while (ops_issued != total_ops || results_seen != total_ops)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (error_count == 0)
            $display("integer_divider_64_top: match");
        else
            $display("integer_divider_64_top: mismatch");
        $finish;
    end

endmodule
